FILE: sv/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg: shared types and constants of the sphere chain fit
// Holds the controller states, the command and status groups between the
// controller and the datapath, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package pcsf_pkg;

  // default sizes
  localparam int unsigned MaxPointsDef  = 1024;
  localparam int unsigned MaxSpheresDef = 32;

  // configuration register indexes
  localparam logic CfgSphereCount = 1'b0;
  localparam logic CfgRadiusScale = 1'b1;

  // configuration reset values
  localparam logic [5:0]  SphereCountRst = 6'd3;
  localparam logic [15:0] RadiusScaleRst = 16'd256;

  // radius floor 0.025 and margin 0.005 on the Q16.16 grid
  localparam logic [33:0] FloorRadius  = 34'd1638;
  localparam logic [33:0] MarginRadius = 34'd328;

  // rounding term of the Q8.8 scale product
  localparam logic [49:0] ScaleRound = 50'd128;

  // square root of a 66-bit value takes one bit of root per step
  localparam int unsigned SqrtSteps = 33;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_SCAN_RD,
    ST_SCAN_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SCAN_CMP,
    ST_SQRT_GO,
    ST_SQRT_RUN,
    ST_RAD_ADD,
    ST_RAD_MUL,
    ST_EMIT
  } fsm_state_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       div_go;
    logic       div_step;
    logic       div_end;
    logic       scan_init;
    logic       diff;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       cmp;
    logic       next_pt;
    logic       sqrt_go;
    logic       sqrt_step;
    logic       rad_add;
    logic       rad_mul;
    logic       emit;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic iter_zero;
    logic last_phase;
    logic last_point;
    logic last_sphere;
    logic out_free;
  } status_t;

endpackage

FILE: sv/pcsf_ctrl.sv
// ----------------------------------------------------------------------------
// pcsf_ctrl: sequencer of the sphere chain fit
// Loads points, then per sphere runs three slab divisions, a scan of the
// point store, a square root and the radius scaling, and hands off a result.
// ----------------------------------------------------------------------------
module pcsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              final_point_i,
  output logic              in_stall_o,
  input  pcsf_pkg::status_t status_i,
  output pcsf_pkg::cmd_t    cmd_o
);

  pcsf_pkg::fsm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcsf_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pcsf_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (final_point_i) begin
            state_d = pcsf_pkg::ST_SETUP;
          end
        end
      end
      pcsf_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = pcsf_pkg::ST_DIV_GO;
      end
      pcsf_pkg::ST_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = pcsf_pkg::ST_DIV_RUN;
      end
      pcsf_pkg::ST_DIV_RUN: begin
        if (status_i.iter_zero) begin
          state_d = pcsf_pkg::ST_DIV_END;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      pcsf_pkg::ST_DIV_END: begin
        cmd_o.div_end = 1'b1;
        if (status_i.last_phase) begin
          cmd_o.scan_init = 1'b1;
          state_d         = pcsf_pkg::ST_SCAN_RD;
        end else begin
          state_d = pcsf_pkg::ST_DIV_GO;
        end
      end
      pcsf_pkg::ST_SCAN_RD: begin
        state_d = pcsf_pkg::ST_SCAN_DIFF;
      end
      pcsf_pkg::ST_SCAN_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = pcsf_pkg::ST_SQ_X;
      end
      pcsf_pkg::ST_SQ_X: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_sel = pcsf_pkg::AXIS_X;
        state_d      = pcsf_pkg::ST_SQ_Y;
      end
      pcsf_pkg::ST_SQ_Y: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_sel = pcsf_pkg::AXIS_Y;
        state_d      = pcsf_pkg::ST_SQ_Z;
      end
      pcsf_pkg::ST_SQ_Z: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_sel = pcsf_pkg::AXIS_Z;
        state_d      = pcsf_pkg::ST_SCAN_CMP;
      end
      pcsf_pkg::ST_SCAN_CMP: begin
        cmd_o.cmp = 1'b1;
        if (status_i.last_point) begin
          state_d = pcsf_pkg::ST_SQRT_GO;
        end else begin
          cmd_o.next_pt = 1'b1;
          state_d       = pcsf_pkg::ST_SCAN_RD;
        end
      end
      pcsf_pkg::ST_SQRT_GO: begin
        cmd_o.sqrt_go = 1'b1;
        state_d       = pcsf_pkg::ST_SQRT_RUN;
      end
      pcsf_pkg::ST_SQRT_RUN: begin
        if (status_i.iter_zero) begin
          state_d = pcsf_pkg::ST_RAD_ADD;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      pcsf_pkg::ST_RAD_ADD: begin
        cmd_o.rad_add = 1'b1;
        state_d       = pcsf_pkg::ST_RAD_MUL;
      end
      pcsf_pkg::ST_RAD_MUL: begin
        cmd_o.rad_mul = 1'b1;
        state_d       = pcsf_pkg::ST_EMIT;
      end
      pcsf_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_sphere) begin
            cmd_o.done = 1'b1;
            state_d    = pcsf_pkg::ST_LOAD;
          end else begin
            state_d = pcsf_pkg::ST_DIV_GO;
          end
        end
      end
      default: begin
        state_d = pcsf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: sv/pcsf_datapath.sv
// ----------------------------------------------------------------------------
// pcsf_datapath: storage and arithmetic of the sphere chain fit
// Point store, bounding box, slab divider, squared distance unit, square
// root, radius scaling, configuration registers and the output register.
// ----------------------------------------------------------------------------
module pcsf_datapath #(
  parameter int unsigned MAX_POINTS  = pcsf_pkg::MaxPointsDef,
  parameter int unsigned MAX_SPHERES = pcsf_pkg::MaxSpheresDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  pcsf_pkg::cmd_t     cmd_i,
  output pcsf_pkg::status_t  status_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic        [4:0]  sphere_index_o,
  output logic signed [31:0] center_x_o,
  output logic signed [31:0] center_y_o,
  output logic signed [31:0] center_z_o,
  output logic        [31:0] fit_radius_o,
  output logic               points_dropped_o,
  output logic               last_sphere_o
);

  localparam int unsigned IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned NW    = $clog2(MAX_SPHERES + 1);
  localparam int unsigned JW    = $clog2(2 * MAX_SPHERES + 1);
  localparam int unsigned NUMW  = 32 + JW;
  localparam int unsigned ITW   = $clog2(NUMW + 1);

  // configuration registers
  logic [5:0]  sphere_count_q;
  logic [15:0] radius_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sphere_count_q <= pcsf_pkg::SphereCountRst;
      radius_scale_q <= pcsf_pkg::RadiusScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcsf_pkg::CfgSphereCount: sphere_count_q <= cfg_data_i[5:0];
        pcsf_pkg::CfgRadiusScale: radius_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // point store, one write port for loading, one registered read for scanning
  logic [95:0]   point_mem_q [MAX_POINTS];
  logic [95:0]   rd_q;
  logic [IW-1:0] addr_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MAX_POINTS))) begin
      point_mem_q[count_q[IW-1:0]] <= {point_z_i, point_y_i, point_x_i};
    end
    rd_q <= point_mem_q[addr_q];
  end

  // fill count and overflow flag
  logic overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (cmd_i.done) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (count_q < CW'(MAX_POINTS)) begin
        count_q <= count_q + CW'(1);
      end else begin
        overflow_q <= 1'b1;
      end
    end
  end

  // running bounding box
  logic signed [31:0] pin [3];
  logic signed [31:0] low_q  [3];
  logic signed [31:0] high_q [3];

  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MAX_POINTS))) begin
      for (int d = 0; d < 3; d++) begin
        if ((count_q == '0) || (pin[d] < low_q[d])) begin
          low_q[d] <= pin[d];
        end
        if ((count_q == '0) || (pin[d] > high_q[d])) begin
          high_q[d] <= pin[d];
        end
      end
    end
  end

  // extents, longest axis and clamped sphere count
  logic [31:0]   ext_d [3];
  logic [31:0]   ext_q [3];
  logic [1:0]    axis_q;
  logic [1:0]    axis_d;
  logic [NW-1:0] n_q;
  logic [NW-1:0] n_d;
  logic [NW-1:0] si_q;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      ext_d[d] = 32'(33'($signed({high_q[d][31], high_q[d]})
                       - $signed({low_q[d][31], low_q[d]})));
    end
    if ((ext_d[1] > ext_d[0]) && (ext_d[1] >= ext_d[2])) begin
      axis_d = pcsf_pkg::AXIS_Y;
    end else if ((ext_d[2] > ext_d[0]) && (ext_d[2] > ext_d[1])) begin
      axis_d = pcsf_pkg::AXIS_Z;
    end else begin
      axis_d = pcsf_pkg::AXIS_X;
    end
    if (sphere_count_q == '0) begin
      n_d = NW'(1);
    end else if ({1'b0, sphere_count_q} > 7'(MAX_SPHERES)) begin
      n_d = NW'(MAX_SPHERES);
    end else begin
      n_d = NW'(sphere_count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      for (int d = 0; d < 3; d++) begin
        ext_q[d] <= ext_d[d];
      end
      axis_q <= axis_d;
      n_q    <= n_d;
    end
  end

  // sphere counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      si_q <= '0;
    end else if (cmd_i.setup) begin
      si_q <= '0;
    end else if (cmd_i.emit) begin
      si_q <= si_q + NW'(1);
    end
  end

  // slab divider: floor(j * extent / 2n), j = 2i, 2i+2, 2i+1 by phase
  logic [1:0]      div_phase_q;
  logic [JW-1:0]   div_j;
  logic [JW-1:0]   div_den;
  logic [NUMW-1:0] div_num;
  logic [NUMW-1:0] quo_q;
  logic [JW-1:0]   rem_q;
  logic [JW:0]     div_trial;
  logic [ITW-1:0]  itc_q;
  logic [31:0]     div_q32;

  // phases 0, 1, 2 add 0, 2, 1: the phase with its two bits swapped
  assign div_j     = JW'({si_q, 1'b0}) + JW'({div_phase_q[0], div_phase_q[1]});
  assign div_den   = JW'({n_q, 1'b0});
  assign div_num   = NUMW'(div_j) * NUMW'(ext_q[axis_q]);
  assign div_trial = {rem_q, quo_q[NUMW-1]};
  assign div_q32   = quo_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_phase_q <= '0;
    end else if (cmd_i.setup) begin
      div_phase_q <= '0;
    end else if (cmd_i.div_end) begin
      div_phase_q <= (div_phase_q == 2'd2) ? 2'd0 : div_phase_q + 2'd1;
    end
  end

  // square root registers share the step counter with the divider
  logic [65:0] best_q;
  logic [65:0] src_q;
  logic [35:0] srem_q;
  logic [32:0] root_q;
  logic [35:0] sq_shift;
  logic [35:0] sq_trial;

  assign sq_shift = {srem_q[33:0], src_q[65:64]};
  assign sq_trial = 36'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itc_q <= '0;
    end else if (cmd_i.div_go) begin
      itc_q <= ITW'(NUMW);
    end else if (cmd_i.sqrt_go) begin
      itc_q <= ITW'(pcsf_pkg::SqrtSteps);
    end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
      itc_q <= itc_q - ITW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      quo_q <= div_num;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_trial >= {1'b0, div_den}) begin
        rem_q <= JW'(div_trial - {1'b0, div_den});
        quo_q <= {quo_q[NUMW-2:0], 1'b1};
      end else begin
        rem_q <= div_trial[JW-1:0];
        quo_q <= {quo_q[NUMW-2:0], 1'b0};
      end
    end
  end

  // slab bounds and sphere centre from the division results
  logic signed [31:0] lo_b_q;
  logic signed [31:0] hi_b_q;
  logic signed [31:0] cen_q [3];
  logic signed [31:0] bound_sum;

  assign bound_sum = 32'(33'($signed({low_q[axis_q][31], low_q[axis_q]})
                         + $signed({1'b0, div_q32})));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_end) begin
      unique case (div_phase_q)
        2'd0: lo_b_q <= bound_sum;
        2'd1: hi_b_q <= bound_sum;
        default: begin
          for (int d = 0; d < 3; d++) begin
            if (2'(d) == axis_q) begin
              cen_q[d] <= bound_sum;
            end else begin
              cen_q[d] <= 32'(33'($signed({low_q[d][31], low_q[d]})
                              + $signed({2'b00, ext_q[d][31:1]})));
            end
          end
        end
      endcase
    end
  end

  // scan address
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      addr_q <= '0;
    end else if (cmd_i.next_pt) begin
      addr_q <= addr_q + IW'(1);
    end
  end

  // slab test and distance components
  logic signed [31:0] rd_pt [3];
  logic        [31:0] diff_q [3];
  logic        [32:0] diff_raw [3];
  logic               in_slab_q;
  logic               in_slab_d;
  logic               last_sph;

  assign rd_pt[0] = rd_q[31:0];
  assign rd_pt[1] = rd_q[63:32];
  assign rd_pt[2] = rd_q[95:64];
  assign last_sph = (si_q == (n_q - NW'(1)));

  always_comb begin
    in_slab_d = (rd_pt[axis_q] >= lo_b_q) && (last_sph || (rd_pt[axis_q] < hi_b_q));
    for (int d = 0; d < 3; d++) begin
      diff_raw[d] = 33'($signed({rd_pt[d][31], rd_pt[d]})
                        - $signed({cen_q[d][31], cen_q[d]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      in_slab_q <= in_slab_d;
      for (int d = 0; d < 3; d++) begin
        diff_q[d] <= diff_raw[d][32] ? 32'(-diff_raw[d]) : diff_raw[d][31:0];
      end
    end
  end

  // squared distance, one axis per cycle on a shared multiplier
  logic [63:0] sq_prod;
  logic [65:0] acc_q;

  assign sq_prod = 64'(diff_q[cmd_i.sq_sel]) * 64'(diff_q[cmd_i.sq_sel]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      if (cmd_i.sq_sel == pcsf_pkg::AXIS_X) begin
        acc_q <= 66'(sq_prod);
      end else begin
        acc_q <= acc_q + 66'(sq_prod);
      end
    end
  end

  // largest squared distance in the slab
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q <= '0;
    end else if (cmd_i.cmp && in_slab_q && (acc_q > best_q)) begin
      best_q <= acc_q;
    end
  end

  // integer square root, two radicand bits per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      src_q  <= best_q;
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      src_q <= {src_q[63:0], 2'b00};
      if (sq_shift >= sq_trial) begin
        srem_q <= sq_shift - sq_trial;
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        srem_q <= sq_shift;
        root_q <= {root_q[31:0], 1'b0};
      end
    end
  end

  // margin, floor and scale with saturation
  logic [33:0] rad_r_q;
  logic [33:0] rad_sum;
  logic [49:0] rad_prod;
  logic [31:0] rad_q;

  assign rad_sum  = 34'(root_q) + pcsf_pkg::MarginRadius;
  assign rad_prod = 50'(rad_r_q) * 50'(radius_scale_q) + pcsf_pkg::ScaleRound;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rad_add) begin
      rad_r_q <= (rad_sum < pcsf_pkg::FloorRadius) ? pcsf_pkg::FloorRadius : rad_sum;
    end
    if (cmd_i.rad_mul) begin
      rad_q <= (rad_prod[49:40] != '0) ? '1 : rad_prod[39:8];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sphere_index_o   <= 5'(si_q);
      center_x_o       <= cen_q[0];
      center_y_o       <= cen_q[1];
      center_z_o       <= cen_q[2];
      fit_radius_o     <= rad_q;
      points_dropped_o <= overflow_q;
      last_sphere_o    <= last_sph;
    end
  end

  // status to the controller
  assign status_o.iter_zero   = (itc_q == '0);
  assign status_o.last_phase  = (div_phase_q == 2'd2);
  assign status_o.last_point  = ((CW'(addr_q) + CW'(1)) >= count_q);
  assign status_o.last_sphere = last_sph;
  assign status_o.out_free    = !out_valid_o || !out_stall_i;

endmodule

FILE: sv/point_cloud_sphere_chain_fit.sv
// ----------------------------------------------------------------------------
// point_cloud_sphere_chain_fit: bounding sphere chain fit of a point cloud
// Stores points and a running box, then places spheres in equal slabs of
// the longest box axis, each sized by the farthest point in its slab.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  points   | in        | in_valid_i / in_stall_o | point_x/y/z_i, final_point_i
//  spheres  | out       | out_valid_o / out_stall_i | sphere_index_o .. last_sphere_o
//  config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// points load one per cycle while in_stall_o is low; a point marked final starts the fit
// a setup at the start of each cloud, then each sphere runs, in order: three
// serial slab divisions, a pass per stored point through the one store read
// port and shared multiplier (read, difference, three squares, compare),
// a 33-step square root, scaling and handoff
// input stalls for the whole fit; the last sphere frees it on handoff
// no clearing pass after reset: the store is covered by its fill count
// ----------------------------------------------------------------------------
module point_cloud_sphere_chain_fit #(
  parameter int unsigned MAX_POINTS  = pcsf_pkg::MaxPointsDef,
  parameter int unsigned MAX_SPHERES = pcsf_pkg::MaxSpheresDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               final_point_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [4:0]  sphere_index_o,
  output logic signed [31:0] center_x_o,
  output logic signed [31:0] center_y_o,
  output logic signed [31:0] center_z_o,
  output logic        [31:0] fit_radius_o,
  output logic               points_dropped_o,
  output logic               last_sphere_o
);

  pcsf_pkg::cmd_t    cmd;
  pcsf_pkg::status_t status;

  // sequencer
  pcsf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .final_point_i (final_point_i),
    .in_stall_o    (in_stall_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // storage and arithmetic
  pcsf_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SPHERES (MAX_SPHERES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .point_z_i        (point_z_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .sphere_index_o   (sphere_index_o),
    .center_x_o       (center_x_o),
    .center_y_o       (center_y_o),
    .center_z_o       (center_z_o),
    .fit_radius_o     (fit_radius_o),
    .points_dropped_o (points_dropped_o),
    .last_sphere_o    (last_sphere_o)
  );

`ifndef NO_ASSERTIONS
  // a sphere is never loaded over a result that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!(out_valid_o && out_stall_i)))
    else $error("sphere loaded over a waiting result");

  // no sphere is handed off in a cycle that takes a point
  a_load_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !cmd.emit)
    else $error("sphere emitted while loading points");

  // the final sphere of a run returns the block to loading
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last_sphere) |=> !in_stall_o)
    else $error("input not released after the last sphere");
`endif

endmodule
